[design/lmts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_pkg
// Types and timing constants shared by the LCD mode timing sequencer.
// ----------------------------------------------------------------------------
package lmts_pkg;

    localparam int DOT_W  = 10;
    localparam int LINE_W = 8;
    localparam int CYC_W  = 7;
    localparam int IRQ_W  = 4;

    localparam logic [DOT_W-1:0]  DOTS_OAM    = 10'd80;
    localparam logic [DOT_W-1:0]  DOTS_XFER   = 10'd172;
    localparam logic [DOT_W-1:0]  DOTS_HBLANK = 10'd204;
    localparam logic [DOT_W-1:0]  DOTS_LINE   = 10'd456;
    localparam logic [DOT_W-1:0]  DOTS_MAX    = 10'd1023;
    localparam logic [LINE_W-1:0] LINE_VBLANK = 8'd144;
    localparam logic [LINE_W-1:0] LINE_LAST   = 8'd153;

    // Bits of the STAT interrupt enable register.
    localparam int IRQ_HBLANK  = 0;
    localparam int IRQ_VBLANK  = 1;
    localparam int IRQ_OAM     = 2;
    localparam int IRQ_COMPARE = 3;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_LCD_ENABLE   = 2'd0;
    localparam logic [1:0] REG_COMPARE_LINE = 2'd1;
    localparam logic [1:0] REG_IRQ_ENABLES  = 2'd2;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcd_mode_t;

    typedef enum logic {
        ACT_ADVANCE   = 1'b0,
        ACT_LINE_CLR  = 1'b1
    } action_t;

    typedef struct packed {
        logic             action;
        logic [CYC_W-1:0] cycles;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        lcd_mode;
        logic [LINE_W-1:0] current_line;
        logic              coincidence;
        logic              vblank_irq;
        logic              stat_irq;
        logic              render_strobe;
        logic              frame_done;
    } res_item_t;

    typedef struct packed {
        logic [DOT_W-1:0]  dot_count;
        logic [LINE_W-1:0] line_count;
        lcd_mode_t         mode;
        logic              match_flag;
    } timing_state_t;

    typedef struct packed {
        logic              lcd_enable;
        logic [LINE_W-1:0] compare_line;
        logic [IRQ_W-1:0]  irq_enables;
    } timing_cfg_t;

endpackage

[design/lmts_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_step
// Next-state and result logic for one request of the timing sequencer.
// ----------------------------------------------------------------------------
module lmts_step
    import lmts_pkg::*;
(
    input  timing_state_t cur,
    input  timing_cfg_t   cfg,
    input  req_item_t     item,
    output timing_state_t nxt,
    output res_item_t     res
);

    logic [DOT_W:0]    dot_sum;
    logic [DOT_W-1:0]  dot_sat;
    logic [LINE_W-1:0] line_inc;
    logic              vbl;
    logic              stat;
    logic              rend;
    logic              frame;
    logic              check;

    assign dot_sum  = {1'b0, cur.dot_count} + {{(DOT_W+1-CYC_W){1'b0}}, item.cycles};
    assign dot_sat  = dot_sum[DOT_W] ? DOTS_MAX : dot_sum[DOT_W-1:0];
    assign line_inc = cur.line_count + 8'd1;

    always_comb
    begin
        nxt   = cur;
        vbl   = 1'b0;
        stat  = 1'b0;
        rend  = 1'b0;
        frame = 1'b0;
        check = 1'b0;
        if (item.action == ACT_LINE_CLR)
        begin
            nxt.line_count = '0;
        end
        else if (!cfg.lcd_enable)
        begin
            nxt.line_count = '0;
            nxt.dot_count  = '0;
            nxt.mode       = MODE_HBLANK;
            stat           = cfg.irq_enables[IRQ_HBLANK];
        end
        else
        begin
            nxt.dot_count = dot_sat;
            unique case (cur.mode)
                MODE_OAM:
                begin
                    if (dot_sat >= DOTS_OAM)
                    begin
                        nxt.dot_count = dot_sat - DOTS_OAM;
                        nxt.mode      = MODE_XFER;
                    end
                end
                MODE_XFER:
                begin
                    if (dot_sat >= DOTS_XFER)
                    begin
                        nxt.dot_count = dot_sat - DOTS_XFER;
                        nxt.mode      = MODE_HBLANK;
                        stat          = cfg.irq_enables[IRQ_HBLANK];
                        rend          = 1'b1;
                    end
                end
                MODE_HBLANK:
                begin
                    if (dot_sat >= DOTS_HBLANK)
                    begin
                        nxt.dot_count  = dot_sat - DOTS_HBLANK;
                        nxt.line_count = line_inc;
                        check          = 1'b1;
                        if (line_inc == LINE_VBLANK)
                        begin
                            nxt.mode = MODE_VBLANK;
                            vbl      = 1'b1;
                            stat     = cfg.irq_enables[IRQ_VBLANK];
                            frame    = 1'b1;
                        end
                        else
                        begin
                            nxt.mode = MODE_OAM;
                            stat     = cfg.irq_enables[IRQ_OAM];
                        end
                    end
                end
                default:
                begin
                    if (dot_sat >= DOTS_LINE)
                    begin
                        nxt.dot_count  = dot_sat - DOTS_LINE;
                        nxt.line_count = line_inc;
                        check          = 1'b1;
                        // Past the last blank line the frame restarts at line zero.
                        if (line_inc > LINE_LAST)
                        begin
                            nxt.line_count = '0;
                            nxt.mode       = MODE_OAM;
                            stat           = cfg.irq_enables[IRQ_OAM];
                        end
                    end
                end
            endcase
            if (check)
            begin
                nxt.match_flag = (nxt.line_count == cfg.compare_line);
                stat = stat | (nxt.match_flag & cfg.irq_enables[IRQ_COMPARE]);
            end
        end
    end

    assign res.lcd_mode      = nxt.mode;
    assign res.current_line  = nxt.line_count;
    assign res.coincidence   = nxt.match_flag;
    assign res.vblank_irq    = vbl;
    assign res.stat_irq      = stat;
    assign res.render_strobe = rend;
    assign res.frame_done    = frame;

endmodule

[design/lcd_mode_timing_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer_unit
// LCD mode timing sequencer with an APB register port.
// ----------------------------------------------------------------------------
// Path: an accepted request is held in the input register, passes through
// the combinational step logic and is stored in the result register.
// Throughput: one request per cycle while the result side is not stalled.
// Reset: the line and dot counters clear, the mode becomes vertical blank,
// the match flag is set and the registers take their reset values.
module lcd_mode_timing_sequencer_unit
    import lmts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_item_t             req_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_item_t             res_item
);

    timing_cfg_t   cfg_reg;
    timing_state_t state_reg;
    timing_state_t state_next;
    res_item_t     step_res;
    req_item_t     in_item_reg;
    logic          in_valid_reg;
    res_item_t     res_item_reg;
    logic          res_valid_reg;
    logic          advance;
    logic          cfg_write;
    logic [1:0]    reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lcd_enable   <= 1'b1;
            cfg_reg.compare_line <= '0;
            cfg_reg.irq_enables  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_LCD_ENABLE:   cfg_reg.lcd_enable   <= pwdata[0];
                REG_COMPARE_LINE: cfg_reg.compare_line <= pwdata[LINE_W-1:0];
                REG_IRQ_ENABLES:  cfg_reg.irq_enables  <= pwdata[IRQ_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_LCD_ENABLE:   prdata = {{(APB_DATA_W-1){1'b0}}, cfg_reg.lcd_enable};
            REG_COMPARE_LINE: prdata = {{(APB_DATA_W-LINE_W){1'b0}}, cfg_reg.compare_line};
            REG_IRQ_ENABLES:  prdata = {{(APB_DATA_W-IRQ_W){1'b0}}, cfg_reg.irq_enables};
            default:          prdata = '0;
        endcase
    end

    // The held request moves on whenever the result register is free or drained.
    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !in_valid_reg || advance;

    lmts_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            res_valid_reg        <= 1'b0;
            state_reg.dot_count  <= '0;
            state_reg.line_count <= '0;
            state_reg.mode       <= MODE_VBLANK;
            state_reg.match_flag <= 1'b1;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_item_reg <= req_item;
        end
        if (advance)
        begin
            res_item_reg <= step_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

`ifndef SYNTHESIS
    // A finished frame is always reported together with the entry to vertical blank.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.frame_done |->
            res_item.vblank_irq && res_item.lcd_mode == MODE_VBLANK
            && res_item.current_line == LINE_VBLANK)
    else $error("frame_done without vertical blank entry at line 144");

    // The end of pixel transfer always lands in horizontal blank.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.render_strobe |->
            res_item.lcd_mode == MODE_HBLANK && !res_item.frame_done)
    else $error("render_strobe outside horizontal blank");

    // An advance while the display is off leaves the counters cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !cfg_reg.lcd_enable && in_item_reg.action == ACT_ADVANCE |=>
            state_reg.dot_count == '0 && state_reg.line_count == '0
            && state_reg.mode == MODE_HBLANK)
    else $error("disabled display did not clear the sequencer");

    // The timing state register holds whenever no request moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
    else $error("timing state changed without a request");
`endif

endmodule

[verif/lmts_timing_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmts_timing_checker
// Watches the register port and both handshake channels of the LCD mode timing
// sequencer. Each accepted request is run through a local copy of the timing
// state, and each accepted result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module lmts_timing_checker
    import lmts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  req_item_t             req_item,
    input  logic                  res_valid,
    input  logic                  res_ready,
    input  res_item_t             res_item,
    output int                    fail_count,
    output int                    pending
);

    timing_state_t tstate;
    timing_cfg_t   tcfg;
    res_item_t     expected_q[$];
    res_item_t     predicted;
    res_item_t     oldest;
    int            n_fail    = 0;
    int            n_pending = 0;
    int            n_res     = 0;

    assign fail_count = n_fail;
    assign pending    = n_pending;

    function automatic logic mode_entry_irq(input lcd_mode_t m);
        case (m)
            MODE_HBLANK: return tcfg.irq_enables[IRQ_HBLANK];
            MODE_VBLANK: return tcfg.irq_enables[IRQ_VBLANK];
            MODE_OAM:    return tcfg.irq_enables[IRQ_OAM];
            default:     return 1'b0;
        endcase
    endfunction

    // Line coincidence is only re-evaluated when the timing moves the line on.
    function automatic logic line_match_irq();
        tstate.match_flag = (tstate.line_count == tcfg.compare_line);
        return tstate.match_flag & tcfg.irq_enables[IRQ_COMPARE];
    endfunction

    task automatic advance_timing(input req_item_t r, output res_item_t y);
        int   dots;
        logic stat;
        logic vbl;
        logic rend;
        logic frame;
        stat  = 1'b0;
        vbl   = 1'b0;
        rend  = 1'b0;
        frame = 1'b0;
        if (r.action == ACT_LINE_CLR) begin
            tstate.line_count = '0;
        end
        else if (!tcfg.lcd_enable) begin
            tstate.line_count = '0;
            tstate.dot_count  = '0;
            tstate.mode       = MODE_HBLANK;
            stat              = mode_entry_irq(MODE_HBLANK);
        end
        else begin
            dots = int'(tstate.dot_count) + int'(r.cycles);
            if (dots > int'(DOTS_MAX))
                dots = int'(DOTS_MAX);
            case (tstate.mode)
                MODE_OAM:
                    if (dots >= int'(DOTS_OAM)) begin
                        dots        -= int'(DOTS_OAM);
                        tstate.mode  = MODE_XFER;
                    end
                MODE_XFER:
                    if (dots >= int'(DOTS_XFER)) begin
                        dots        -= int'(DOTS_XFER);
                        tstate.mode  = MODE_HBLANK;
                        stat         = mode_entry_irq(MODE_HBLANK);
                        rend         = 1'b1;
                    end
                MODE_HBLANK:
                    if (dots >= int'(DOTS_HBLANK)) begin
                        dots              -= int'(DOTS_HBLANK);
                        tstate.line_count  = tstate.line_count + 8'd1;
                        if (tstate.line_count == LINE_VBLANK) begin
                            tstate.mode = MODE_VBLANK;
                            stat        = mode_entry_irq(MODE_VBLANK);
                            vbl         = 1'b1;
                            frame       = 1'b1;
                        end
                        else begin
                            tstate.mode = MODE_OAM;
                            stat        = mode_entry_irq(MODE_OAM);
                        end
                        stat |= line_match_irq();
                    end
                default:
                    if (dots >= int'(DOTS_LINE)) begin
                        dots              -= int'(DOTS_LINE);
                        tstate.line_count  = tstate.line_count + 8'd1;
                        if (tstate.line_count > LINE_LAST) begin
                            tstate.line_count = '0;
                            tstate.mode       = MODE_OAM;
                            stat              = mode_entry_irq(MODE_OAM);
                        end
                        stat |= line_match_irq();
                    end
            endcase
            tstate.dot_count = dots[DOT_W-1:0];
        end
        y.lcd_mode      = tstate.mode;
        y.current_line  = tstate.line_count;
        y.coincidence   = tstate.match_flag;
        y.vblank_irq    = vbl;
        y.stat_irq      = stat;
        y.render_strobe = rend;
        y.frame_done    = frame;
    endtask

    task automatic compare_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            n_fail++;
            if (n_fail <= 10)
                $display("Result %0d, %s: expected %0d, got %0d", n_res, field, want_v,
                         got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tstate    = '{dot_count: '0, line_count: '0, mode: MODE_VBLANK,
                          match_flag: 1'b1};
            tcfg      = '{lcd_enable: 1'b1, compare_line: '0, irq_enables: '0};
            expected_q.delete();
            n_pending = 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_LCD_ENABLE:   tcfg.lcd_enable   = pwdata[0];
                    REG_COMPARE_LINE: tcfg.compare_line = pwdata[LINE_W-1:0];
                    REG_IRQ_ENABLES:  tcfg.irq_enables  = pwdata[IRQ_W-1:0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready) begin
                advance_timing(req_item, predicted);
                expected_q.push_back(predicted);
            end
            if (res_valid && res_ready) begin
                if (expected_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("Result %0d arrived with no request outstanding", n_res);
                end
                else begin
                    oldest = expected_q.pop_front();
                    compare_field("lcd_mode", oldest.lcd_mode, res_item.lcd_mode);
                    compare_field("current_line", oldest.current_line,
                                  res_item.current_line);
                    compare_field("coincidence", oldest.coincidence, res_item.coincidence);
                    compare_field("vblank_irq", oldest.vblank_irq, res_item.vblank_irq);
                    compare_field("stat_irq", oldest.stat_irq, res_item.stat_irq);
                    compare_field("render_strobe", oldest.render_strobe,
                                  res_item.render_strobe);
                    compare_field("frame_done", oldest.frame_done, res_item.frame_done);
                end
                n_res++;
            end
            n_pending = expected_q.size();
        end
    end

endmodule

[verif/tb_lcd_mode_timing_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcd_mode_timing_sequencer_unit
// Drives the LCD mode timing sequencer with a short directed sequence and then
// long runs of random dot advances and line clears under several register
// settings and idling patterns. The checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_sequencer_unit;
    import lmts_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid;
    logic                  req_ready;
    req_item_t             req_item;
    logic                  res_valid;
    logic                  res_ready;
    res_item_t             res_item;
    int                    fail_count;
    int                    pending;
    int                    tx_idle_pct;
    int                    rx_idle_pct;

    always #5 clk = ~clk;

    lcd_mode_timing_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    lmts_timing_checker timing_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_item   (req_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
            res_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Valid is only dropped while idling, so back-to-back requests keep it high.
    task automatic send_req(input action_t act, input logic [CYC_W-1:0] cyc);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= '{action: act, cycles: cyc};
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Mostly large advances, so that whole frames and the vertical blank wrap
    // are reached; line clears are kept rare since each one restarts the frame.
    task automatic send_random_req();
        int pick;
        pick = $urandom_range(0, 999);
        if (pick < 2)
            send_req(ACT_LINE_CLR, CYC_W'($urandom_range(0, 127)));
        else if (pick < 680)
            send_req(ACT_ADVANCE, CYC_W'($urandom_range(90, 127)));
        else if (pick < 900)
            send_req(ACT_ADVANCE, CYC_W'($urandom_range(0, 80)));
        else
            send_req(ACT_ADVANCE, CYC_W'($urandom_range(0, 127)));
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        int compare_sel;
        logic [LINE_W-1:0] cmp;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        req_valid   = 1'b0;
        req_item    = '0;
        tx_idle_pct = 29;
        rx_idle_pct = 69;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_write(REG_IRQ_ENABLES, 32'hF);
        reg_write(REG_COMPARE_LINE, 32'd1);
        // Vertical blank straight after reset, then a line clear.
        send_req(ACT_ADVANCE, 7'd0);
        send_req(ACT_ADVANCE, 7'd127);
        send_req(ACT_LINE_CLR, 7'd127);
        wait_idle();

        // Display off: every advance forces horizontal blank.
        reg_write(REG_LCD_ENABLE, 32'd0);
        send_req(ACT_ADVANCE, 7'd127);
        send_req(ACT_ADVANCE, 7'd0);
        send_req(ACT_LINE_CLR, 7'd0);
        wait_idle();
        reg_write(REG_LCD_ENABLE, 32'd1);

        // One line through each mode, exact thresholds and carried dots.
        send_req(ACT_ADVANCE, 7'd127);
        send_req(ACT_ADVANCE, 7'd76);
        send_req(ACT_ADVANCE, 7'd1);
        send_req(ACT_ADVANCE, 7'd80);
        send_req(ACT_ADVANCE, 7'd127);
        send_req(ACT_ADVANCE, 7'd45);
        send_req(ACT_ADVANCE, 7'd127);
        send_req(ACT_ADVANCE, 7'd127);
        send_req(ACT_ADVANCE, 7'd30);
        send_req(ACT_LINE_CLR, 7'd85);
        send_req(ACT_ADVANCE, 7'd127);
        send_req(ACT_ADVANCE, 7'd127);
        wait_idle();

        reg_write(REG_LCD_ENABLE, 32'd0);
        repeat (8) send_random_req();
        wait_idle();
        reg_write(REG_LCD_ENABLE, 32'd1);

        for (int phase = 0; phase < 3; phase++) begin
            for (int blk = 0; blk < 3; blk++) begin
                wait_idle();
                tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 69 : 0;
                rx_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 29 : 0;
                compare_sel = $urandom_range(0, 4);
                case (compare_sel)
                    0:       cmp = 8'd0;
                    1:       cmp = 8'd255;
                    2:       cmp = LINE_VBLANK;
                    3:       cmp = LINE_LAST;
                    default: cmp = LINE_W'($urandom_range(0, 153));
                endcase
                reg_write(REG_COMPARE_LINE, APB_DATA_W'(cmp));
                if (blk == 0)
                    reg_write(REG_IRQ_ENABLES, (phase == 1) ? 32'h0 : 32'hF);
                else
                    reg_write(REG_IRQ_ENABLES, APB_DATA_W'($urandom_range(0, 15)));
                repeat (85) send_random_req();
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
design/lmts_pkg.sv
design/lmts_step.sv
design/lcd_mode_timing_sequencer_unit.sv
verif/lmts_timing_checker.sv
verif/tb_lcd_mode_timing_sequencer_unit.sv
